// File: sv/torus_vertex_generator_defines.svh
// Assertion macros shared by the torus vertex generator RTL.
// Included by the files that carry concurrent assertions; needs a clk and rst in scope.
`ifndef TORUS_VERTEX_GENERATOR_DEFINES_SVH
`define TORUS_VERTEX_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define TVG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("torus vertex generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define TVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("torus vertex generator: next-cycle check failed");

// As above, but also checked while reset is asserted.
`define TVG_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("torus vertex generator: reset check failed");

`endif

// File: sv/tvg_pkg.sv
// Shared constants for the torus vertex generator: widths, CORDIC tables and codes.
// No dependencies; used by every module of the block.
`default_nettype none

package tvg_pkg;

  // Phase divider: index * 2^24 / steps, four quotient bits per stage.
  localparam int PHASE_W    = 24;
  localparam int DIV_W      = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;

  // CORDIC datapath width (Q2.30 plus a guard bit) and output width.
  localparam int CORDIC_W = 33;
  localparam int TRIG_W   = 32;

  localparam int MAX_STEPS = 255;

  localparam logic [30:0]                 HALFPI_Q30   = 31'd1686629713;
  localparam logic signed [CORDIC_W-1:0]  CORDIC_START = 33'sd652032874;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // Quadrant of the phase.
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_U_STEPS      = 2'd0;
  localparam logic [1:0] CFG_V_STEPS      = 2'd1;
  localparam logic [1:0] CFG_MAJOR_RADIUS = 2'd2;
  localparam logic [1:0] CFG_MINOR_RADIUS = 2'd3;

endpackage

`default_nettype wire

// File: sv/tvg_phase.sv
// Phase unit: pipelined restoring divider for index/steps of a turn, then angle scaling.
// Depends on tvg_pkg. Each divider stage is registered, and theta and quad are registered after the scaling.
`default_nettype none

module tvg_phase (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [7:0]  index,
  input  wire logic [7:0]  steps,
  output logic      [30:0] theta,
  output logic      [1:0]  quad
);

  logic [7:0]                  rem_q [1:tvg_pkg::DIV_STAGES];
  logic [tvg_pkg::PHASE_W-1:0] quo_q [1:tvg_pkg::DIV_STAGES];
  logic [7:0]                  idx_q [1:tvg_pkg::DIV_STAGES];

  // Divider stages, each producing four quotient bits.
  for (genvar s = 0; s < tvg_pkg::DIV_STAGES; s++) begin : g_div
    logic [7:0]                  rem_in, rem_n, idx_in;
    logic [tvg_pkg::PHASE_W-1:0] quo_in, quo_n;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign idx_in = index;
    end else begin : g_rest
      assign rem_in = rem_q[s];
      assign quo_in = quo_q[s];
      assign idx_in = idx_q[s];
    end

    always_comb begin
      logic [8:0]               r9;
      logic [tvg_pkg::DIV_W-1:0] dvd;
      dvd   = {idx_in, 24'd0};
      rem_n = rem_in;
      quo_n = quo_in;
      r9    = '0;
      for (int k = 0; k < tvg_pkg::DIV_STEP; k++) begin
        r9 = {rem_n, dvd[tvg_pkg::DIV_W - 1 - s * tvg_pkg::DIV_STEP - k]};
        if (r9 >= {1'b0, steps}) begin
          r9    = r9 - {1'b0, steps};
          quo_n = {quo_n[tvg_pkg::PHASE_W-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[tvg_pkg::PHASE_W-2:0], 1'b0};
        end
        rem_n = r9[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= rem_n;
        quo_q[s+1] <= quo_n;
        idx_q[s+1] <= idx_in;
      end
    end
  end

  // A zero step count gives phase zero; the residual scales to Q2.30 radians.
  logic [tvg_pkg::PHASE_W-1:0] phase;
  logic [52:0]                 angle_prod;

  assign phase      = (steps == 8'd0) ? '0 : quo_q[tvg_pkg::DIV_STAGES];
  assign angle_prod = 53'(phase[21:0]) * 53'(tvg_pkg::HALFPI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= angle_prod[52:22];
      quad  <= phase[23:22];
    end
  end

endmodule

`default_nettype wire

// File: sv/tvg_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, then quadrant mapping.
// Depends on tvg_pkg. The quadrant-mapped result is registered after the last iteration.
`default_nettype none

module tvg_cordic #(
  parameter int ITERATIONS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic        [30:0]                 theta,
  input  wire logic        [1:0]                  quad,
  output logic signed      [tvg_pkg::TRIG_W-1:0]  cos_out,
  output logic signed      [tvg_pkg::TRIG_W-1:0]  sin_out
);

  localparam int W = tvg_pkg::CORDIC_W;

  logic signed [W-1:0] x_q [1:ITERATIONS];
  logic signed [W-1:0] y_q [1:ITERATIONS];
  logic signed [W-1:0] z_q [1:ITERATIONS];
  logic        [1:0]   quad_q [1:ITERATIONS];

  // Micro-rotation stages.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    logic signed [W-1:0] x_in, y_in, z_in, x_n, y_n, z_n, dx, dy, at;
    logic        [1:0]   quad_in;

    if (k == 0) begin : g_first
      assign x_in    = tvg_pkg::CORDIC_START;
      assign y_in    = '0;
      assign z_in    = $signed({2'b00, theta});
      assign quad_in = quad;
    end else begin : g_rest
      assign x_in    = x_q[k];
      assign y_in    = y_q[k];
      assign z_in    = z_q[k];
      assign quad_in = quad_q[k];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;
    assign at = $signed({1'b0, tvg_pkg::ATAN_Q30[k]});

    always_comb begin
      if (!z_in[W-1]) begin
        x_n = x_in - dx;
        y_n = y_in + dy;
        z_n = z_in - at;
      end else begin
        x_n = x_in + dx;
        y_n = y_in - dy;
        z_n = z_in + at;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k+1]    <= x_n;
        y_q[k+1]    <= y_n;
        z_q[k+1]    <= z_n;
        quad_q[k+1] <= quad_in;
      end
    end
  end

  // Map the first-quadrant result onto the full turn.
  logic signed [W-1:0] c_n, s_n, xf, yf;

  assign xf = x_q[ITERATIONS];
  assign yf = y_q[ITERATIONS];

  always_comb begin
    case (quad_q[ITERATIONS])
      tvg_pkg::QUAD_FIRST: begin
        c_n = xf;
        s_n = yf;
      end
      tvg_pkg::QUAD_SECOND: begin
        c_n = -yf;
        s_n = xf;
      end
      tvg_pkg::QUAD_THIRD: begin
        c_n = -xf;
        s_n = -yf;
      end
      default: begin
        c_n = yf;
        s_n = -xf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= c_n[tvg_pkg::TRIG_W-1:0];
      sin_out <= s_n[tvg_pkg::TRIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/tvg_geom.sv
// Geometry stages: products, rounding and saturation of position and normal.
// Depends on tvg_pkg for the trig width. Each stage ends in a register.
`default_nettype none

module tvg_geom (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [tvg_pkg::TRIG_W-1:0]  cu,
  input  wire logic signed [tvg_pkg::TRIG_W-1:0]  su,
  input  wire logic signed [tvg_pkg::TRIG_W-1:0]  cv,
  input  wire logic signed [tvg_pkg::TRIG_W-1:0]  sv,
  input  wire logic        [15:0]                 major_r,
  input  wire logic        [15:0]                 minor_r,
  output logic signed      [17:0]                 pos_x,
  output logic signed      [17:0]                 pos_y,
  output logic signed      [17:0]                 pos_z,
  output logic signed      [15:0]                 norm_x,
  output logic signed      [15:0]                 norm_y,
  output logic signed      [15:0]                 norm_z
);

  localparam int TW = tvg_pkg::TRIG_W;

  function automatic logic signed [17:0] sat18(input logic signed [65:0] v);
    if (v < -66'sd131072)     return -18'sd131072;
    else if (v > 66'sd131071) return 18'sd131071;
    else                      return v[17:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    if (v < -66'sd32768)     return -16'sd32768;
    else if (v > 66'sd32767) return 16'sd32767;
    else                     return v[15:0];
  endfunction

  // Stage one: the products against the tube angle.
  logic signed [48:0]   pu1, pz1;
  logic signed [63:0]   nx1, ny1;
  logic signed [TW-1:0] cv1, sv1, su1;
  logic        [15:0]   major1;

  always_ff @(posedge clk) begin
    if (en) begin
      pu1    <= $signed({1'b0, minor_r}) * cu;
      pz1    <= $signed({1'b0, minor_r}) * su;
      nx1    <= cv * cu;
      ny1    <= sv * cu;
      cv1    <= cv;
      sv1    <= sv;
      su1    <= su;
      major1 <= major_r;
    end
  end

  // Stage two: ring distance, tube height and the normal, rounded half up.
  logic signed [49:0] dsum, pzr;
  logic signed [64:0] nxr, nyr;
  logic signed [32:0] nzr;
  logic signed [27:0] d2;
  logic signed [17:0] pz2, pz3;
  logic signed [15:0] nx2, ny2, nz2, nx3, ny3, nz3;
  logic signed [TW-1:0] cv2, sv2;

  assign dsum = $signed({4'd0, major1, 30'd0}) + 50'(pu1) + 50'sd2097152;
  assign pzr  = 50'(pz1) + 50'sd536870912;
  assign nxr  = 65'(nx1) + 65'sd17592186044416;
  assign nyr  = -65'(ny1) + 65'sd17592186044416;
  assign nzr  = 33'(su1) + 33'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= dsum[49:22];
      pz2 <= sat18(66'(pzr >>> 30));
      nx2 <= sat16(66'(nxr >>> 45));
      ny2 <= sat16(66'(nyr >>> 45));
      nz2 <= sat16(66'(nzr >>> 15));
      cv2 <= cv1;
      sv2 <= sv1;
    end
  end

  // Stage three: position products against the ring angle.
  logic signed [59:0] pxp, pyp;

  always_ff @(posedge clk) begin
    if (en) begin
      pxp <= d2 * cv2;
      pyp <= d2 * sv2;
      pz3 <= pz2;
      nx3 <= nx2;
      ny3 <= ny2;
      nz3 <= nz2;
    end
  end

  // Stage four: final rounding and saturation into the output register.
  logic signed [60:0] pxr, pyr;

  assign pxr = 61'(pxp) + 61'sd137438953472;
  assign pyr = -61'(pyp) + 61'sd137438953472;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x  <= sat18(66'(pxr >>> 38));
      pos_y  <= sat18(66'(pyr >>> 38));
      pos_z  <= pz3;
      norm_x <= nx3;
      norm_y <= ny3;
      norm_z <= nz3;
    end
  end

endmodule

`default_nettype wire

// File: sv/torus_vertex_generator.sv
// Torus vertex generator top level: configuration, valid pipeline and datapath units.
// It accepts one item per cycle while the output is not stalled, set by the fully
// pipelined divider, CORDIC and multiplier stages.
// The whole pipeline holds while a finished result waits and the output is not taken.
// Synchronous reset empties the pipeline and restores the register defaults.
// Depends on tvg_pkg, tvg_phase, tvg_cordic, tvg_geom and the assertion header.
`default_nettype none

`include "torus_vertex_generator_defines.svh"

module torus_vertex_generator #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [15:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [7:0]  u_index,
  input  wire logic        [7:0]  v_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [17:0] pos_x,
  output logic signed      [17:0] pos_y,
  output logic signed      [17:0] pos_z,
  output logic signed      [15:0] norm_x,
  output logic signed      [15:0] norm_y,
  output logic signed      [15:0] norm_z,
  output logic             [15:0] vertex_number,
  output logic                    index_error
);

  localparam int LAT = tvg_pkg::DIV_STAGES + 1 + CORDIC_ITERATIONS + 1 + 4;

  // Configuration registers.
  logic [7:0]  u_steps, v_steps;
  logic [15:0] major_radius, minor_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_steps      <= 8'd80;
      v_steps      <= 8'd80;
      major_radius <= 16'd256;
      minor_radius <= 16'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        tvg_pkg::CFG_U_STEPS:      u_steps      <= cfg_data[7:0];
        tvg_pkg::CFG_V_STEPS:      v_steps      <= cfg_data[7:0];
        tvg_pkg::CFG_MAJOR_RADIUS: major_radius <= cfg_data;
        tvg_pkg::CFG_MINOR_RADIUS: minor_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Vertex number and error flag are worked out on entry.
  logic [17:0] vnum_full;
  logic        err_entry;

  assign vnum_full = 18'(v_index) * 18'({1'b0, u_steps} + 9'd1) + 18'(u_index);
  assign err_entry = (u_index > u_steps) || (v_index > v_steps) ||
                     (u_steps == 8'd0) || (v_steps == 8'd0) ||
                     (u_steps > 8'(tvg_pkg::MAX_STEPS)) ||
                     (v_steps > 8'(tvg_pkg::MAX_STEPS)) ||
                     (vnum_full[17:16] != 2'd0);

  // Valid bits and side data travel alongside the datapath stages.
  logic        vld    [LAT];
  logic [15:0] vnum_d [LAT];
  logic        err_d  [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vnum_d[0] <= vnum_full[15:0];
      err_d[0]  <= err_entry;
      for (int i = 1; i < LAT; i++) begin
        vnum_d[i] <= vnum_d[i-1];
        err_d[i]  <= err_d[i-1];
      end
    end
  end

  assign out_valid     = vld[LAT-1];
  assign vertex_number = vnum_d[LAT-1];
  assign index_error   = err_d[LAT-1];

  // Angle phases for both axes.
  logic [30:0] theta_u, theta_v;
  logic [1:0]  quad_u, quad_v;

  tvg_phase u_phase_u (
    .clk   (clk),
    .en    (en),
    .index (u_index),
    .steps (u_steps),
    .theta (theta_u),
    .quad  (quad_u)
  );

  tvg_phase u_phase_v (
    .clk   (clk),
    .en    (en),
    .index (v_index),
    .steps (v_steps),
    .theta (theta_v),
    .quad  (quad_v)
  );

  // Sine and cosine for both axes.
  logic signed [tvg_pkg::TRIG_W-1:0] cu, su, cv, sv;

  tvg_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_u (
    .clk     (clk),
    .en      (en),
    .theta   (theta_u),
    .quad    (quad_u),
    .cos_out (cu),
    .sin_out (su)
  );

  tvg_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_v (
    .clk     (clk),
    .en      (en),
    .theta   (theta_v),
    .quad    (quad_v),
    .cos_out (cv),
    .sin_out (sv)
  );

  // Position and normal.
  tvg_geom u_geom (
    .clk     (clk),
    .en      (en),
    .cu      (cu),
    .su      (su),
    .cv      (cv),
    .sv      (sv),
    .major_r (major_radius),
    .minor_r (minor_radius),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z),
    .norm_x  (norm_x),
    .norm_y  (norm_y),
    .norm_z  (norm_z)
  );

  // Checks on the pipeline control.
  `TVG_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !out_valid && !vld[0])
  `TVG_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[0])
  `TVG_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(vertex_number) && $stable(pos_x))

endmodule

`default_nettype wire

// File: sim/tvg_vertex_checker.sv
// Vertex checker for the torus vertex generator: predicts each vertex from the accepted
// grid point and compares it with the accepted result. Depends on tvg_pkg only.
`timescale 1ns / 100ps

module tvg_vertex_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [7:0]  u_index,
  input  logic        [7:0]  v_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [17:0] pos_x,
  input  logic signed [17:0] pos_y,
  input  logic signed [17:0] pos_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic        [15:0] vertex_number,
  input  logic               index_error,
  output int                 fail_count,
  output int                 pending
);

  localparam int ITERATIONS = 16;

  typedef struct packed {
    logic signed [17:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0] vnum;
    logic err;
  } vertex_t;

  vertex_t expected_vertices[$];
  logic [7:0]  u_steps_q, v_steps_q;
  logic [15:0] major_q, minor_q;

  // Arithmetic shift right with floor, on 64-bit signed values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Cosine and sine in Q2.30 of index/steps of a full turn.
  function automatic void angle_trig(input logic [7:0] idx, input logic [7:0] steps,
                                     output longint c, output longint s);
    longint unsigned p;
    logic [1:0] quad;
    longint x, y, z, dx, dy;
    p = 0;
    x = tvg_pkg::CORDIC_START;
    y = 0;
    if (steps != 0) p = ((longint'(idx) << 24) / steps) & 64'hFFFFFF;
    quad = p[23:22];
    z = longint'(((p & 64'h3FFFFF) * longint'(tvg_pkg::HALFPI_Q30)) >> 22);
    for (int k = 0; k < ITERATIONS; k++) begin
      dx = floor_shift(y, k);
      dy = floor_shift(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tvg_pkg::ATAN_Q30[k]);
      end else begin
        x += dx; y -= dy; z += longint'(tvg_pkg::ATAN_Q30[k]);
      end
    end
    case (quad)
      tvg_pkg::QUAD_FIRST:  begin c = x;  s = y;  end
      tvg_pkg::QUAD_SECOND: begin c = -y; s = x;  end
      tvg_pkg::QUAD_THIRD:  begin c = -x; s = -y; end
      default:              begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic vertex_t torus_vertex(logic [7:0] ui, logic [7:0] vi);
    vertex_t r;
    longint cu, su, cv, sv, d;
    int unsigned lin;
    angle_trig(ui, u_steps_q, cu, su);
    angle_trig(vi, v_steps_q, cv, sv);
    d = round_shift((longint'(major_q) <<< 30) + longint'(minor_q) * cu, 22);
    r.px = 18'(clamp(round_shift(d * cv, 38), -131072, 131071));
    r.py = 18'(clamp(round_shift(-(d * sv), 38), -131072, 131071));
    r.pz = 18'(clamp(round_shift(longint'(minor_q) * su, 30), -131072, 131071));
    r.nx = 16'(clamp(round_shift(cv * cu, 45), -32768, 32767));
    r.ny = 16'(clamp(round_shift(-(sv * cu), 45), -32768, 32767));
    r.nz = 16'(clamp(round_shift(su, 15), -32768, 32767));
    lin = vi * (u_steps_q + 1) + ui;
    r.vnum = lin[15:0];
    r.err = (ui > u_steps_q) || (vi > v_steps_q) || (u_steps_q == 0) ||
            (v_steps_q == 0) || (lin >= 65536);
    return r;
  endfunction

  assign pending = expected_vertices.size();

  // Track registers, queue predictions and compare accepted results.
  always @(posedge clk) begin
    vertex_t want, got;
    if (rst) begin
      u_steps_q <= 8'd80;
      v_steps_q <= 8'd80;
      major_q   <= 16'd256;
      minor_q   <= 16'd64;
      fail_count <= 0;
      expected_vertices.delete();
    end else begin
      if (in_valid && in_ready) expected_vertices.push_back(torus_vertex(u_index, v_index));
      if (out_valid && out_ready) begin
        got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_number, index_error};
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_vertices.pop_front();
          if (want !== got) begin
            $display({"%0t: vertex mismatch expected px=%0d py=%0d pz=%0d",
                      " nx=%0d ny=%0d nz=%0d n=%0d e=%0b"},
                     $time, want.px, want.py, want.pz, want.nx, want.ny, want.nz,
                     want.vnum, want.err);
            $display({"%0t:                   actual px=%0d py=%0d pz=%0d",
                      " nx=%0d ny=%0d nz=%0d n=%0d e=%0b"},
                     $time, got.px, got.py, got.pz, got.nx, got.ny, got.nz,
                     got.vnum, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          tvg_pkg::CFG_U_STEPS:      u_steps_q <= cfg_data[7:0];
          tvg_pkg::CFG_V_STEPS:      v_steps_q <= cfg_data[7:0];
          tvg_pkg::CFG_MAJOR_RADIUS: major_q   <= cfg_data;
          tvg_pkg::CFG_MINOR_RADIUS: minor_q   <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: sim/tb_torus_vertex_generator.sv
// Testbench top for the torus vertex generator: clock, reset, grid point stimulus,
// register phases and verdict. Depends on tvg_pkg, the block and tvg_vertex_checker.
`timescale 1ns / 100ps

module tb_torus_vertex_generator;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = tvg_pkg::CFG_U_STEPS;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] u_index = '0, v_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [15:0] vertex_number;
  logic index_error;
  int fail_count, pending, idle_cycles;
  logic [7:0] u_steps_now, v_steps_now;

  always #4 clk = ~clk;

  torus_vertex_generator i_dut (.*);

  tvg_vertex_checker i_checker (.*);

  // Receiver stalls on a pattern of its own: long ready stretches and random holds.
  always @(posedge clk) begin
    int phase_cnt;
    phase_cnt = $urandom_range(0, 99);
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($time / 8000) % 3 == 0 ? 1'b1 : phase_cnt < 65;
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("torus_vertex_generator regression: fail");
      $finish;
    end
  end

  task automatic send_point(input logic [7:0] ui, input logic [7:0] vi);
    in_valid <= 1'b1;
    u_index <= ui;
    v_index <= vi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One register write, then the write enable drops low again before the task returns.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == tvg_pkg::CFG_U_STEPS) u_steps_now = val[7:0];
    if (idx == tvg_pkg::CFG_V_STEPS) v_steps_now = val[7:0];
  endtask

  // Wait for every result, then let the pipeline fall quiet.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Bursts of random grid points, mostly inside the grid, with random gaps.
  task automatic random_points(input int count);
    int burst;
    int gap;
    logic [7:0] ui, vi;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 9) < 8) begin
        ui = 8'($urandom_range(0, u_steps_now));
        vi = 8'($urandom_range(0, v_steps_now));
      end else begin
        ui = 8'($urandom);
        vi = 8'($urandom);
      end
      send_point(ui, vi);
      burst--;
    end
  endtask

  initial begin
    u_steps_now = 8'd80;
    v_steps_now = 8'd80;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners at reset settings.
    send_point(8'd0, 8'd0);
    send_point(8'd80, 8'd80);
    send_point(8'd20, 8'd40);
    send_point(8'd60, 8'd10);
    send_point(8'd81, 8'd0);
    send_point(8'd0, 8'd81);
    send_point(8'd255, 8'd255);
    send_point(8'hAA, 8'h55);
    send_point(8'h55, 8'hAA);
    drain();

    // Extremes: largest grid and maximum radii.
    write_reg(tvg_pkg::CFG_U_STEPS, 16'hFFFF);
    write_reg(tvg_pkg::CFG_V_STEPS, 16'd255);
    write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'hFFFF);
    write_reg(tvg_pkg::CFG_MINOR_RADIUS, 16'hFFFF);
    send_point(8'd255, 8'd255);
    send_point(8'd0, 8'd255);
    send_point(8'd64, 8'd192);
    send_point(8'd128, 8'd1);
    random_points(200);
    drain();

    // Zero step counts and zero radii.
    write_reg(tvg_pkg::CFG_U_STEPS, 16'd0);
    write_reg(tvg_pkg::CFG_V_STEPS, 16'd0);
    write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'd0);
    write_reg(tvg_pkg::CFG_MINOR_RADIUS, 16'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd3, 8'd7);
    drain();

    // Single step counts, small radii.
    write_reg(tvg_pkg::CFG_U_STEPS, 16'd1);
    write_reg(tvg_pkg::CFG_V_STEPS, 16'd1);
    write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'd1);
    write_reg(tvg_pkg::CFG_MINOR_RADIUS, 16'd384);
    send_point(8'd1, 8'd1);
    send_point(8'd0, 8'd1);
    random_points(100);
    drain();

    // Random settings, several phases.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(tvg_pkg::CFG_U_STEPS, 16'($urandom_range(1, 255)));
      write_reg(tvg_pkg::CFG_V_STEPS, 16'($urandom_range(1, 255)));
      write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'($urandom));
      write_reg(tvg_pkg::CFG_MINOR_RADIUS, 16'($urandom));
      random_points(200);
      drain();
    end

    // Back to the defaults for the last stretch.
    write_reg(tvg_pkg::CFG_U_STEPS, 16'd80);
    write_reg(tvg_pkg::CFG_V_STEPS, 16'd80);
    write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'd256);
    write_reg(tvg_pkg::CFG_MINOR_RADIUS, 16'd64);
    random_points(40);
    drain();

    if (fail_count == 0) $display("torus_vertex_generator regression: pass");
    else $display("torus_vertex_generator regression: fail");
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/tvg_pkg.sv
sv/tvg_phase.sv
sv/tvg_cordic.sv
sv/tvg_geom.sv
sv/torus_vertex_generator.sv
sim/tvg_vertex_checker.sv
sim/tb_torus_vertex_generator.sv
